FILE: rtl/dkt_pkg.sv
// ----------------------------------------------------------------------------
// dkt_pkg
// Shared types and constants for the dense keyed table with random pick.
// ----------------------------------------------------------------------------
`default_nettype none

package dkt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DRAW_W = 16;

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] val_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_PICK   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [31:0]       key;
        logic [31:0]       value;
        logic [DRAW_W-1:0] draw;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [31:0] key_out;
        logic [4:0]  entries;
    } rsp_word_t;

endpackage

`default_nettype wire

FILE: rtl/dkt_ram.sv
// ----------------------------------------------------------------------------
// dkt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/dense_keyed_table_with_random_pick_top.sv
// ----------------------------------------------------------------------------
// dense_keyed_table_with_random_pick_top
// Key/value table packed in slots 0..count-1 with find, insert, remove and
// random pick; keys are located by a linear scan of the key RAM.
//
//   channel  handshake             payload      role
//   req      req_valid/req_stall   req_word_t   operation in
//   rsp      rsp_valid/rsp_stall   rsp_word_t   one result per operation
//
// A scan reads one slot per cycle from the key and value RAMs, whose read
// ports are registered; find and remove scan, insert scans, may move the
// last entry into a freed slot and then appends, and pick reads one slot.
// One operation is in flight at a time; req is stalled until it finishes.
// rsp is registered, so a new word is taken while the last result waits.
// Reset clears the entry count; RAM contents are never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_keyed_table_with_random_pick_top
    import dkt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MOVE   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_PICK   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]  state_reg, state_next;
    cnt_t        cnt_reg, cnt_next;
    idx_t        cmp_idx_reg, cmp_idx_next;
    idx_t        slot_reg, slot_next;
    logic [1:0]  mode_reg, mode_next;
    key_t        key_reg, key_next;
    val_t        val_reg, val_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] vout_reg, vout_next;
    logic [31:0] kout_reg, kout_next;
    rsp_word_t   rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // RAM ports
    idx_t rd_addr;
    idx_t wr_addr;
    logic wr_en;
    key_t wr_key;
    val_t wr_val;
    key_t key_rd;
    val_t val_rd;

    dkt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_key),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    dkt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_val),
        .raddr (rd_addr),
        .rdata (val_rd)
    );

    // pick slot = (draw * count) >> 16
    logic [DRAW_W+CNT_W-1:0] pick_prod;
    cnt_t                    pick_q;
    idx_t                    pick_slot;
    idx_t                    last_idx;
    logic                    hit;
    logic                    drops;

    assign pick_prod = (DRAW_W + CNT_W)'(req.draw) * (DRAW_W + CNT_W)'(cnt_reg);
    assign pick_q    = pick_prod[DRAW_W+CNT_W-1:DRAW_W];
    assign pick_slot = (pick_q >= cnt_t'(CAPACITY)) ? idx_t'(CAPACITY - 1)
                                                    : pick_q[IDX_W-1:0];
    assign last_idx  = idx_t'(cnt_reg - cnt_t'(1));
    assign hit       = (key_rd == key_reg);
    assign drops     = (mode_reg == MODE_INSERT) || (mode_reg == MODE_REMOVE);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        vout_next      = vout_reg;
        kout_next      = kout_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_addr        = cmp_idx_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_key         = key_rd;
        wr_val         = val_rd;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next    = req.mode;
                    key_next     = key_t'(req.key);
                    val_next     = val_t'(req.value);
                    status_next  = ST_OK;
                    vout_next    = '0;
                    kout_next    = '0;
                    cmp_idx_next = '0;
                    rd_addr      = '0;
                    if (req.mode == MODE_PICK)
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            rd_addr    = pick_slot;
                            state_next = S_PICK;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        // empty table: nothing to scan
                        if (req.mode == MODE_INSERT)
                        begin
                            state_next = S_APPEND;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    slot_next = cmp_idx_reg;
                    if (!drops)
                    begin
                        vout_next  = 32'(val_rd);
                        state_next = S_DONE;
                    end
                    else if (cmp_idx_reg == last_idx)
                    begin
                        // last slot: just shrink
                        cnt_next   = cnt_reg - cnt_t'(1);
                        state_next = (mode_reg == MODE_INSERT) ? S_APPEND : S_DONE;
                    end
                    else
                    begin
                        rd_addr    = last_idx;
                        state_next = S_MOVE;
                    end
                end
                else if (cmp_idx_reg == last_idx)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + idx_t'(1);
                    rd_addr      = cmp_idx_reg + idx_t'(1);
                end
            end

            S_MOVE:
            begin
                // fill the freed slot with the last entry
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_key     = key_rd;
                wr_val     = val_rd;
                cnt_next   = cnt_reg - cnt_t'(1);
                state_next = (mode_reg == MODE_INSERT) ? S_APPEND : S_DONE;
            end

            S_APPEND:
            begin
                if (cnt_reg >= cnt_t'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cnt_reg[IDX_W-1:0];
                    wr_key   = key_reg;
                    wr_val   = val_reg;
                    cnt_next = cnt_reg + cnt_t'(1);
                end
                state_next = S_DONE;
            end

            S_PICK:
            begin
                kout_next  = 32'(key_rd);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status    = status_reg;
                    rsp_next.value_out = vout_reg;
                    rsp_next.key_out   = kout_reg;
                    rsp_next.entries   = 5'(cnt_reg);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        vout_reg    <= vout_next;
        kout_reg    <= kout_next;
        rsp_reg     <= rsp_next;
    end

endmodule

`default_nettype wire

FILE: bench/dense_keyed_table_with_random_pick_top_tb.sv
// ----------------------------------------------------------------------------
// dense_keyed_table_with_random_pick_top_tb
// Self-checking bench for the dense keyed table. A directed table walks the
// empty, full and last-slot corners. Random traffic follows, drawn from a
// small key pool so that finds, removes and re-inserts hit stored entries.
// A shadow copy of the table predicts every reply. Both handshakes idle at
// random, and one long reply hold-off backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_keyed_table_with_random_pick_top_tb;
    import dkt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE    = 20;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CHUNK_ITEMS  = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
        logic [15:0] draw;
        int          reps;
        bit          typed;
        rsp_word_t   want;
    } probe_row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    // shadow copy of the table
    key_t model_keys [CAPACITY];
    val_t model_vals [CAPACITY];
    int   model_count = 0;

    rsp_word_t  table_replies[$];
    probe_row_t probe_rows[$];

    int  mismatch_count = 0;
    int  req_idle_pct   = 0;
    int  rsp_stall_pct  = 0;
    bit  hold_off_req   = 1'b0;

    dense_keyed_table_with_random_pick_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Swap-remove: the last entry fills the freed slot.
    function automatic void model_drop(input int slot);
        model_keys[slot] = model_keys[model_count - 1];
        model_vals[slot] = model_vals[model_count - 1];
        model_count--;
    endfunction

    function automatic rsp_word_t table_model_apply(input req_word_t w);
        rsp_word_t r;
        key_t      k;
        int        hit;
        int        slot;
        int        i;
        r   = '0;
        k   = w.key[KEY_BITS-1:0];
        hit = -1;
        for (i = 0; i < model_count; i++)
        begin
            if (hit < 0 && model_keys[i] == k)
                hit = i;
        end
        case (w.mode)
            MODE_FIND:
            begin
                if (hit >= 0)
                    r.value_out = 32'(model_vals[hit]);
                else
                    r.status = ST_NOT_FOUND;
            end
            MODE_INSERT:
            begin
                if (hit >= 0)
                    model_drop(hit);
                if (model_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    model_keys[model_count] = k;
                    model_vals[model_count] = w.value[VALUE_BITS-1:0];
                    model_count++;
                end
            end
            MODE_REMOVE:
            begin
                if (hit >= 0)
                    model_drop(hit);
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
                if (model_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    slot = (int'(w.draw) * model_count) >> 16;
                    if (slot >= CAPACITY)
                        slot = CAPACITY - 1;
                    r.key_out = 32'(model_keys[slot]);
                end
            end
        endcase
        r.entries = 5'(model_count);
        return r;
    endfunction

    function automatic void add_probe(input logic [1:0] mode, input logic [31:0] key,
                                      input logic [31:0] value, input logic [15:0] draw,
                                      input int reps, input bit typed, input rsp_word_t want);
        probe_row_t row;
        row.mode  = mode;
        row.key   = key;
        row.value = value;
        row.draw  = draw;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        probe_rows.push_back(row);
    endfunction

    // Offer one word, hold it until taken, then queue its reply.
    task automatic offer_word(input req_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t predicted;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = table_model_apply(w);
        table_replies.push_back(typed ? want : predicted);
    endtask

    task automatic set_traffic(input int phase);
        case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 71; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin req_idle_pct = 11; rsp_stall_pct = 11; end
        endcase
    endtask

    // reply side stall, with one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (table_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reply: st=%0d val=%h key=%h n=%0d",
                             rsp.status, rsp.value_out, rsp.key_out, rsp.entries);
            end
            else
            begin
                want = table_replies.pop_front();
                if (rsp.status !== want.status || rsp.value_out !== want.value_out ||
                    rsp.key_out !== want.key_out || rsp.entries !== want.entries)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("reply mismatch at %0t: got st=%0d val=%h key=%h n=%0d, want st=%0d val=%h key=%h n=%0d",
                                 $realtime, rsp.status, rsp.value_out, rsp.key_out,
                                 rsp.entries, want.status, want.value_out,
                                 want.key_out, want.entries);
                end
            end
        end
    end

    initial
    begin
        req_word_t w;
        key_t      key_pool [POOL_SIZE];
        int        n;
        int        i;
        int        chunk;
        int        roll;
        bit        fill_bias;

        // empty table corners
        add_probe(MODE_PICK,   32'h0, 32'h0, 16'h8000, 1, 1'b1,
                  {ST_EMPTY, 32'h0, 32'h0, 5'd0});
        add_probe(MODE_FIND,   32'h0, 32'h0, 16'h0, 1, 1'b1,
                  {ST_NOT_FOUND, 32'h0, 32'h0, 5'd0});
        add_probe(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0, 1, 1'b1,
                  {ST_NOT_FOUND, 32'h0, 32'h0, 5'd0});
        add_probe(MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd1});
        add_probe(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd2});
        add_probe(MODE_FIND,   32'h0, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'hFFFF_FFFF, 32'h0, 5'd2});
        add_probe(MODE_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd2});
        add_probe(MODE_PICK,   32'h0, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd2});
        add_probe(MODE_PICK,   32'h0, 32'h0, 16'hFFFF, 1, 1'b1,
                  {ST_OK, 32'h0, 32'hFFFF_FFFF, 5'd2});
        // re-insert moves key 0 behind the other entry
        add_probe(MODE_INSERT, 32'h0, 32'h5A5A_5A5A, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd2});
        add_probe(MODE_PICK,   32'h0, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'hFFFF_FFFF, 5'd2});
        add_probe(MODE_FIND,   32'h0, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h5A5A_5A5A, 32'h0, 5'd2});
        // fill up, then the full-table corners
        add_probe(MODE_INSERT, 32'h0000_1000, 32'hC000_0000, 16'h0, CAPACITY - 2, 1'b0, '0);
        add_probe(MODE_INSERT, 32'hDEAD_BEEF, 32'h1, 16'h0, 1, 1'b1,
                  {ST_FULL, 32'h0, 32'h0, 5'd16});
        add_probe(MODE_INSERT, 32'h0000_1005, 32'hA5A5_A5A5, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd16});
        add_probe(MODE_PICK,   32'h0, 32'h0, 16'hFFFF, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0000_1005, 5'd16});
        add_probe(MODE_FIND,   32'h0000_1005, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'hA5A5_A5A5, 32'h0, 5'd16});
        add_probe(MODE_FIND,   32'hDEAD_BEEF, 32'h0, 16'h0, 1, 1'b1,
                  {ST_NOT_FOUND, 32'h0, 32'h0, 5'd16});
        add_probe(MODE_REMOVE, 32'h0000_1005, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd15});
        add_probe(MODE_REMOVE, 32'h0, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd14});
        add_probe(MODE_FIND,   32'h0000_100D, 32'h0, 16'h0, 1, 1'b0, '0);
        add_probe(MODE_PICK,   32'h0, 32'h0, 16'h8000, 1, 1'b0, '0);
        add_probe(MODE_REMOVE, 32'h0000_1000, 32'h0, 16'h0, CAPACITY - 2, 1'b0, '0);
        add_probe(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0, 1, 1'b1,
                  {ST_OK, 32'h0, 32'h0, 5'd0});
        add_probe(MODE_PICK,   32'h0, 32'h0, 16'h8000, 1, 1'b1,
                  {ST_EMPTY, 32'h0, 32'h0, 5'd0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (probe_rows[r])
        begin
            for (n = 0; n < probe_rows[r].reps; n++)
            begin
                w.mode  = probe_rows[r].mode;
                w.key   = probe_rows[r].key + n;
                w.value = probe_rows[r].value + n;
                w.draw  = probe_rows[r].draw;
                offer_word(w, probe_rows[r].typed, probe_rows[r].want);
            end
        end

        // a pool a bit larger than the table keeps hits frequent and fills it
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = key_t'($urandom);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % CHUNK_ITEMS == 0)
            begin
                chunk = i / CHUNK_ITEMS;
                set_traffic(chunk % 4);
                if (chunk == 4)
                    hold_off_req = 1'b1;
            end
            fill_bias = ((chunk / 2) % 2 == 0);
            roll = $urandom_range(99);
            if (fill_bias)
                w.mode = (roll < 45) ? MODE_INSERT : (roll < 65) ? MODE_FIND :
                         (roll < 80) ? MODE_REMOVE : MODE_PICK;
            else
                w.mode = (roll < 20) ? MODE_INSERT : (roll < 45) ? MODE_FIND :
                         (roll < 80) ? MODE_REMOVE : MODE_PICK;
            // mostly pool keys, some noise keys that miss
            w.key   = ($urandom_range(99) < 8) ? $urandom
                                               : key_pool[$urandom_range(POOL_SIZE - 1)];
            w.value = $urandom;
            roll    = $urandom_range(9);
            w.draw  = (roll == 0) ? 16'h0 : (roll == 1) ? 16'hFFFF
                                          : 16'($urandom_range(65535));
            offer_word(w, 1'b0, '0);
        end

        req_valid <= 1'b0;
        set_traffic(0);
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && table_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
